// ----- rtl/controlled_soft_limiter_unit_macros.svh -----
// Assertion helpers for the limiter RTL.
`ifndef CONTROLLED_SOFT_LIMITER_UNIT_MACROS_SVH
`define CONTROLLED_SOFT_LIMITER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CSL_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define CSL_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define CSL_ASSERT_SAME(label, clk, rst_n, pre, post)
`define CSL_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

// ----- rtl/csl_pkg.sv -----
package csl_pkg;

    localparam int DW = 32;
    localparam int QBITS = 16;
    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] Q_ONE = 32'sd65536;

    // stage counts: six setup stages, one per quotient bit, two to finish
    localparam int N_PRE = 6;
    localparam int N_DIV = QBITS;
    localparam int N_ST = N_PRE + N_DIV + 2;

    typedef enum logic [2:0] {
        REG_OFFSET  = 3'd0,
        REG_GAIN    = 3'd1,
        REG_LDELTA  = 3'd2,
        REG_UDELTA  = 3'd3,
        REG_SRANGE  = 3'd4,
        REG_PERCENT = 3'd5
    } t_reg;

    typedef enum logic [1:0] {
        PK_ONE       = 2'd0,
        PK_ONE_MINUS = 2'd1,
        PK_DIRECT    = 2'd2
    } t_pk;

    typedef struct packed {
        logic signed [DW-1:0] sum;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] lo;
        logic signed [DW-1:0] hi;
        logic signed [DW-1:0] span;
        logic signed [DW-1:0] r;
        logic signed [DW-1:0] rr;
        logic signed [DW-1:0] tl;
        logic signed [DW-1:0] tu;
        logic signed [DW-1:0] edl;
        logic signed [DW-1:0] edu;
        logic signed [DW-1:0] e;
        logic signed [DW:0]   num2;
        t_pk                  kind;
        logic                 lower;
        logic                 upper;
        logic                 knee;
        logic                 err;
        logic [DW-1:0]        n1;
        logic [DW-1:0]        d1;
        logic [QBITS-1:0]     q1;
        logic                 fx1;
        logic [QBITS:0]       fv1;
        logic [DW-1:0]        n2;
        logic [DW-1:0]        d2;
        logic [QBITS-1:0]     q2;
        logic                 fx2;
        logic [QBITS:0]       fv2;
        logic signed [DW-1:0] m1;
        logic signed [DW-1:0] pk;
        logic signed [DW-1:0] sq;
        logic signed [DW-1:0] lim;
        logic signed [DW-1:0] pin;
        logic signed [DW-1:0] pl;
        logic signed [DW-1:0] pu;
    } t_item;

    function automatic logic signed [DW-1:0] sat_wide(input logic signed [DW+1:0] v);
        if (v > $signed({{2{1'b0}}, SMAX})) begin
            return SMAX;
        end else if (v < $signed({{2{1'b1}}, SMIN})) begin
            return SMIN;
        end
        return v[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] add_s(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
        return sat_wide($signed({{2{a[DW-1]}}, a}) + $signed({{2{b[DW-1]}}, b}));
    endfunction

    function automatic logic signed [DW-1:0] sub_s(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
        return sat_wide($signed({{2{a[DW-1]}}, a}) - $signed({{2{b[DW-1]}}, b}));
    endfunction

    // Q16.16 product, magnitude rounded half away from zero, saturated
    function automatic logic signed [DW-1:0] mulq(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        logic signed [2*DW-1:0] p;
        logic [2*DW-1:0] mag;
        logic [2*DW-1:0] m;
        logic neg;
        p = $signed({{DW{a[DW-1]}}, a}) * $signed({{DW{b[DW-1]}}, b});
        neg = a[DW-1] ^ b[DW-1];
        mag = p[2*DW-1] ? (2*DW)'(-p) : (2*DW)'(p);
        m = (mag + (2*DW)'(32768)) >> QBITS;
        if (!neg) begin
            return (m > (2*DW)'(SMAX)) ? SMAX : m[DW-1:0];
        end
        return (m >= {{DW{1'b0}}, SMIN}) ? SMIN : DW'(-m[DW-1:0]);
    endfunction

endpackage

// ----- rtl/controlled_soft_limiter_unit.sv -----
// One item per cycle sustained while the output is not stalled.
// Six setup stages, sixteen stages of the two parallel knee dividers (one
// quotient bit each), then a multiply stage and a blend stage.
// A stall at the output holds every stage; no bubble is squeezed out.
// Reset (i_rst_n low, synchronous) clears all valid bits and sets the
// registers to their defaults (gain 1.0, everything else zero).
`include "controlled_soft_limiter_unit_macros.svh"

module controlled_soft_limiter_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // input_value [31:0], upper_control [63:32], lower_control [95:64]
    input  logic [3*csl_pkg::DW-1:0] i_s_axis_tdata,
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // limited_output, slope_wrt_input, slope_wrt_lower, slope_wrt_upper
    output logic [4*csl_pkg::DW-1:0] o_m_axis_tdata,
    // range_error [0]
    output logic [0:0]              o_m_axis_tuser,
    input  logic                    i_psel,
    input  logic                    i_penable,
    input  logic                    i_pwrite,
    input  logic [4:0]              i_paddr,
    input  logic [31:0]             i_pwdata,
    output logic [31:0]             o_prdata,
    output logic                    o_pready
);
    import csl_pkg::*;

    logic signed [DW-1:0] r_offset, r_gain, r_ldelta, r_udelta;
    logic [DW-2:0]        r_srange;
    logic                 r_percent;
    t_reg                 w_idx;
    logic                 w_wr;

    t_item r_st [N_ST];
    t_item n_st [N_ST];
    logic  r_v  [N_ST];
    logic  w_adv;

    assign o_pready = 1'b1;
    assign w_idx    = t_reg'(i_paddr[4:2]);
    assign w_wr     = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_gain    <= Q_ONE;
            r_ldelta  <= '0;
            r_udelta  <= '0;
            r_srange  <= '0;
            r_percent <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_OFFSET:  r_offset  <= i_pwdata;
                REG_GAIN:    r_gain    <= i_pwdata;
                REG_LDELTA:  r_ldelta  <= i_pwdata;
                REG_UDELTA:  r_udelta  <= i_pwdata;
                REG_SRANGE:  r_srange  <= i_pwdata[DW-2:0];
                REG_PERCENT: r_percent <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_OFFSET:  o_prdata = r_offset;
            REG_GAIN:    o_prdata = r_gain;
            REG_LDELTA:  o_prdata = r_ldelta;
            REG_UDELTA:  o_prdata = r_udelta;
            REG_SRANGE:  o_prdata = {1'b0, r_srange};
            REG_PERCENT: o_prdata = {31'd0, r_percent};
            default:     o_prdata = '0;
        endcase
    end

    assign w_adv           = !r_v[N_ST-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    always_comb begin
        t_item c;
        logic signed [DW:0]   rmf;
        logic signed [DW-1:0] f;
        logic signed [DW-1:0] s_v, q_v, sq2, half;
        logic [DW:0]          two_n;
        logic signed [DW:0]   d2s;

        // stage 0: offset and limits
        c = '0;
        c.sum = add_s(r_offset, i_s_axis_tdata[DW-1:0]);
        c.hi  = sub_s(i_s_axis_tdata[2*DW-1:DW], r_udelta);
        c.lo  = add_s(i_s_axis_tdata[3*DW-1:2*DW], r_ldelta);
        n_st[0] = c;

        // stage 1: gain and limit span
        c = r_st[0];
        c.y    = mulq(r_gain, c.sum);
        c.span = sub_s(c.hi, c.lo);
        n_st[1] = c;

        // stage 2: knee half-width
        c = r_st[1];
        c.r = r_percent ? mulq({1'b0, r_srange}, c.span) : {1'b0, r_srange};
        n_st[2] = c;

        // stage 3: thresholds and knee edges
        c = r_st[2];
        c.tl  = add_s(c.lo, c.r);
        c.tu  = sub_s(c.hi, c.r);
        c.edl = sub_s(c.lo, c.r);
        c.edu = add_s(c.hi, c.r);
        c.rr  = add_s(c.r, c.r);
        c.err = (c.tu < c.tl);
        n_st[3] = c;

        // stage 4: region, divider numerators
        c = r_st[3];
        c.lower = (c.y < c.tl);
        c.upper = !c.lower && (c.y > c.tu);
        c.kind  = PK_ONE;
        c.num2  = '0;
        c.knee  = 1'b0;
        c.e     = '0;
        if (c.lower) begin
            c.knee = (c.r > 0) && (c.y > c.edl);
            c.e    = sub_s(c.y, c.edl);
            f      = sub_s(c.y, c.lo);
        end else begin
            c.knee = (c.r > 0) && (c.y < c.edu);
            c.e    = sub_s(c.edu, c.y);
            f      = sub_s(c.hi, c.y);
        end
        rmf = $signed({c.r[DW-1], c.r}) - $signed({f[DW-1], f});
        if (c.lower) begin
            if (f < 0) begin
                c.kind = PK_ONE;
            end else if ($signed({f[DW-1], f}) < rmf) begin
                c.kind = PK_ONE_MINUS;
                c.num2 = {f[DW-1], f};
            end else begin
                c.kind = PK_DIRECT;
                c.num2 = rmf;
            end
        end else begin
            if (f <= 0) begin
                c.kind = PK_ONE;
            end else if ($signed({f[DW-1], f}) > rmf) begin
                c.kind = PK_DIRECT;
                c.num2 = rmf;
            end else begin
                c.kind = PK_ONE_MINUS;
                c.num2 = {f[DW-1], f};
            end
        end
        n_st[4] = c;

        // stage 5: divider set-up, trivial quotients settled here
        c = r_st[4];
        c.q1 = '0;
        c.q2 = '0;
        c.n1 = c.e;
        c.d1 = c.rr;
        c.fx1 = 1'b1;
        if (c.e <= 0 || c.rr <= 0) begin
            c.fv1 = '0;
        end else if (c.e >= c.rr) begin
            c.fv1 = {1'b1, {QBITS{1'b0}}};
        end else begin
            c.fx1 = 1'b0;
            c.fv1 = '0;
        end
        d2s  = {c.r[DW-1], c.r};
        c.n2 = c.num2[DW-1:0];
        c.d2 = c.r;
        c.fx2 = 1'b1;
        if (c.num2 <= 0 || c.r <= 0) begin
            c.fv2 = '0;
        end else if (c.num2 >= d2s) begin
            c.fv2 = {1'b1, {QBITS{1'b0}}};
        end else begin
            c.fx2 = 1'b0;
            c.fv2 = '0;
        end
        n_st[5] = c;

        // one restoring step per stage for both quotients
        for (int k = 0; k < N_DIV; k++) begin
            c = r_st[N_PRE-1+k];
            two_n = {c.n1, 1'b0};
            if (two_n >= {1'b0, c.d1}) begin
                c.q1 = {c.q1[QBITS-2:0], 1'b1};
                c.n1 = DW'(two_n - {1'b0, c.d1});
            end else begin
                c.q1 = {c.q1[QBITS-2:0], 1'b0};
                c.n1 = two_n[DW-1:0];
            end
            two_n = {c.n2, 1'b0};
            if (two_n >= {1'b0, c.d2}) begin
                c.q2 = {c.q2[QBITS-2:0], 1'b1};
                c.n2 = DW'(two_n - {1'b0, c.d2});
            end else begin
                c.q2 = {c.q2[QBITS-2:0], 1'b0};
                c.n2 = two_n[DW-1:0];
            end
            n_st[N_PRE+k] = c;
        end

        // products
        c = r_st[N_PRE+N_DIV-1];
        s_v  = c.fx1 ? DW'(c.fv1) : DW'(c.q1);
        q_v  = c.fx2 ? DW'(c.fv2) : DW'(c.q2);
        c.m1 = mulq(c.e, s_v);
        c.pk = mulq(r_gain, s_v);
        c.sq = mulq(q_v, q_v);
        n_st[N_PRE+N_DIV] = c;

        // blend
        c = r_st[N_PRE+N_DIV];
        sq2  = c.sq <<< 1;
        half = (c.m1 + DW'(c.m1[DW-1])) >>> 1;
        c.pl = '0;
        c.pu = '0;
        if (c.lower || c.upper) begin
            if (c.knee) begin
                c.lim = c.lower ? add_s(c.lo, half) : sub_s(c.hi, half);
                c.pin = c.pk;
                unique case (c.kind)
                    PK_ONE_MINUS: f = sub_s(Q_ONE, sq2);
                    PK_DIRECT:    f = sq2;
                    default:      f = Q_ONE;
                endcase
            end else begin
                c.lim = c.lower ? c.lo : c.hi;
                c.pin = '0;
                f     = Q_ONE;
            end
            if (c.lower) begin
                c.pl = f;
            end else begin
                c.pu = f;
            end
        end else begin
            c.lim = c.y;
            c.pin = r_gain;
        end
        n_st[N_PRE+N_DIV+1] = c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_ST; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_v[0] <= i_s_axis_tvalid;
            for (int k = 1; k < N_ST; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < N_ST; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_m_axis_tvalid = r_v[N_ST-1];
    assign o_m_axis_tdata  = {r_st[N_ST-1].pu, r_st[N_ST-1].pl,
                              r_st[N_ST-1].pin, r_st[N_ST-1].lim};
    assign o_m_axis_tuser  = r_st[N_ST-1].err;

    `CSL_ASSERT_NEXT(a_enter, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r_v[0])
    `CSL_ASSERT_SAME(a_div_range, i_clk, i_rst_n, r_v[N_PRE] && r_st[N_PRE].fx1, r_st[N_PRE].fv1 == '0 || r_st[N_PRE].fv1 == {1'b1, {QBITS{1'b0}}})
    `CSL_ASSERT_SAME(a_one_side, i_clk, i_rst_n, o_m_axis_tvalid, r_st[N_ST-1].pl == '0 || r_st[N_ST-1].pu == '0)

endmodule
